FILE: rtl/e2bmw_pkg.sv
// ----------------------------------------------------------------------------
// e2bmw_pkg
// Shared types, codes and helpers for the ext2 block map walker.
// ----------------------------------------------------------------------------
package e2bmw_pkg;

  // field widths
  localparam int WORD_W   = 32;
  localparam int ADDR_W   = 48;
  localparam int LOG_W    = 3;
  localparam int SLOT_W   = 4;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int LEV_W    = 2;
  localparam int LIM_W    = 44;
  localparam int LP_W     = 4;
  localparam int SH_W     = 5;

  // inode pointer layout
  localparam int POINTER_SLOTS = 15;
  localparam int DIRECT_SLOTS  = 12;
  localparam int SLOT_SINGLE   = 12;
  localparam int SLOT_DOUBLE   = 13;
  localparam int SLOT_TRIPLE   = 14;
  localparam int WORD_SHIFT    = 2;
  localparam int PTR_SHIFT     = 8;
  localparam int LOG_MAX       = 6;

  // default queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESP   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_READ   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MAPPED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HOLE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BEYOND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REJECT = 3'd4;

  // classified work kinds
  typedef enum logic [2:0] {
    K_LOAD,
    K_DIRECT,
    K_INDIRECT,
    K_BEYOND,
    K_RESP,
    K_REJECT
  } kind_t;

  // one queued work item
  typedef struct packed {
    kind_t              kind;
    logic [LEV_W-1:0]   level;
    logic [SLOT_W-1:0]  slot;
    logic [WORD_W-1:0]  value;
  } entry_t;

  // clamp the block size code to its top legal value
  function automatic logic [LOG_W-1:0] eff_log(input logic [LOG_W-1:0] lg);
    return (lg > LOG_W'(LOG_MAX)) ? LOG_W'(LOG_MAX) : lg;
  endfunction

  // first logical index past the single, double or triple range
  function automatic logic [LIM_W-1:0] range_limit(input logic [LOG_W-1:0] lg,
                                                   input logic [LEV_W-1:0] lvl);
    logic [LP_W-1:0]  lp;
    logic [LIM_W-1:0] p1;
    logic [LIM_W-1:0] p2;
    logic [LIM_W-1:0] p3;
    logic [LIM_W-1:0] lim;
    lp  = LP_W'(PTR_SHIFT) + LP_W'(lg);
    p1  = LIM_W'(1) << lp;
    p2  = p1 << lp;
    p3  = p2 << lp;
    lim = LIM_W'(DIRECT_SLOTS) + p1;
    if (lvl >= LEV_W'(1)) lim = lim + p2;
    if (lvl >= LEV_W'(2)) lim = lim + p3;
    return lim;
  endfunction

endpackage

FILE: rtl/e2bmw_in_if.sv
// ----------------------------------------------------------------------------
// e2bmw_in_if
// Command channel into the block map walker.
// ----------------------------------------------------------------------------
interface e2bmw_in_if;
  import e2bmw_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [SLOT_W-1:0]   slot;
  logic [WORD_W-1:0]   pointer_value;
  logic [WORD_W-1:0]   logical_index;
  logic [WORD_W-1:0]   read_data;

  modport source (
    output valid, command, slot, pointer_value, logical_index, read_data,
    input  ready
  );

  modport sink (
    input  valid, command, slot, pointer_value, logical_index, read_data,
    output ready
  );
endinterface

FILE: rtl/e2bmw_out_if.sv
// ----------------------------------------------------------------------------
// e2bmw_out_if
// Result channel out of the block map walker.
// ----------------------------------------------------------------------------
interface e2bmw_out_if;
  import e2bmw_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   read_address;
  logic [WORD_W-1:0]   block_number;

  modport source (
    output valid, status, read_address, block_number,
    input  ready
  );

  modport sink (
    input  valid, status, read_address, block_number,
    output ready
  );
endinterface

FILE: rtl/e2bmw_front.sv
// ----------------------------------------------------------------------------
// e2bmw_front
// Accepts command beats and classifies them: slot checks, mapping range and
// offset within the indirect range.
// ----------------------------------------------------------------------------
module e2bmw_front (
  e2bmw_in_if.sink                   in_ch,
  input  logic [e2bmw_pkg::LOG_W-1:0] lg,
  input  logic                       q_full,
  output logic                       push,
  output e2bmw_pkg::entry_t          push_entry
);
  import e2bmw_pkg::*;

  logic [LIM_W-1:0] idx_ext;
  logic [LIM_W-1:0] lim_single;
  logic [LIM_W-1:0] lim_double;
  logic [LIM_W-1:0] lim_triple;

  // take a beat whenever the queue has room
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // range boundaries for the current block size
  assign idx_ext    = LIM_W'(in_ch.logical_index);
  assign lim_single = range_limit(lg, LEV_W'(0));
  assign lim_double = range_limit(lg, LEV_W'(1));
  assign lim_triple = range_limit(lg, LEV_W'(2));

  // classify the beat
  always_comb begin
    push_entry       = '0;
    push_entry.kind  = K_REJECT;
    case (in_ch.command)
      CMD_LOAD: begin
        if (in_ch.slot < SLOT_W'(POINTER_SLOTS)) begin
          push_entry.kind  = K_LOAD;
          push_entry.slot  = in_ch.slot;
          push_entry.value = in_ch.pointer_value;
        end
      end
      CMD_LOOKUP: begin
        if (in_ch.logical_index < WORD_W'(DIRECT_SLOTS)) begin
          push_entry.kind = K_DIRECT;
          push_entry.slot = in_ch.logical_index[SLOT_W-1:0];
        end else if (idx_ext < lim_single) begin
          push_entry.kind  = K_INDIRECT;
          push_entry.level = LEV_W'(0);
          push_entry.slot  = SLOT_W'(SLOT_SINGLE);
          push_entry.value = in_ch.logical_index - WORD_W'(DIRECT_SLOTS);
        end else if (idx_ext < lim_double) begin
          push_entry.kind  = K_INDIRECT;
          push_entry.level = LEV_W'(1);
          push_entry.slot  = SLOT_W'(SLOT_DOUBLE);
          push_entry.value = in_ch.logical_index - lim_single[WORD_W-1:0];
        end else if (idx_ext < lim_triple) begin
          push_entry.kind  = K_INDIRECT;
          push_entry.level = LEV_W'(2);
          push_entry.slot  = SLOT_W'(SLOT_TRIPLE);
          push_entry.value = in_ch.logical_index - lim_double[WORD_W-1:0];
        end else begin
          push_entry.kind = K_BEYOND;
        end
      end
      CMD_RESP: begin
        push_entry.kind  = K_RESP;
        push_entry.value = in_ch.read_data;
      end
      default: begin
        push_entry.kind = K_REJECT;
      end
    endcase
  end

endmodule

FILE: rtl/e2bmw_queue.sv
// ----------------------------------------------------------------------------
// e2bmw_queue
// Small fifo of classified work between front and back.
// ----------------------------------------------------------------------------
module e2bmw_queue #(
  parameter int DEPTH = e2bmw_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  e2bmw_pkg::entry_t push_entry,
  input  logic              pop,
  output e2bmw_pkg::entry_t head,
  output logic              full,
  output logic              empty
);
  import e2bmw_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + IDX_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + IDX_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: rtl/e2bmw_back.sv
// ----------------------------------------------------------------------------
// e2bmw_back
// Executes queued work against the pointer slots and walk state, and
// holds the result beat in an output register.
// ----------------------------------------------------------------------------
module e2bmw_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [e2bmw_pkg::LOG_W-1:0] lg,
  input  e2bmw_pkg::entry_t          head,
  input  logic                       head_valid,
  output logic                       pop,
  e2bmw_out_if.source                out_ch
);
  import e2bmw_pkg::*;

  // pointer slots and walk state
  logic [WORD_W-1:0]   ptr_tab_r [POINTER_SLOTS];
  logic [WORD_W-1:0]   walk_offset_r, walk_offset_nxt;
  logic [LEV_W-1:0]    levels_left_r, levels_left_nxt;
  logic                walk_busy_r, walk_busy_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [WORD_W-1:0]   blk_r, blk_nxt;

  // execution datapath
  logic                tab_we;
  logic                res_valid;
  logic [STATUS_W-1:0] res_status;
  logic [WORD_W-1:0]   res_blk;
  logic                do_issue;
  logic [WORD_W-1:0]   issue_blk;
  logic [LEV_W-1:0]    issue_lev;
  logic [WORD_W-1:0]   issue_off;
  logic [WORD_W-1:0]   slot_ptr;
  logic [LP_W-1:0]     lp;
  logic [SH_W-1:0]     lev_shift;
  logic [WORD_W-1:0]   entry_mask;
  logic [WORD_W-1:0]   entry_idx;
  logic [ADDR_W-1:0]   issue_addr;

  assign pop      = head_valid && (!out_valid_r || out_ch.ready);
  assign slot_ptr = ptr_tab_r[head.slot];
  assign lp       = LP_W'(PTR_SHIFT) + LP_W'(lg);

  // pointer word address for the level being issued
  always_comb begin
    case (issue_lev)
      2'd0:    lev_shift = '0;
      2'd1:    lev_shift = SH_W'(lp);
      2'd2:    lev_shift = SH_W'({lp, 1'b0});
      default: lev_shift = '0;
    endcase
    entry_mask = (WORD_W'(1) << lp) - WORD_W'(1);
    entry_idx  = (issue_off >> lev_shift) & entry_mask;
    issue_addr = (ADDR_W'(issue_blk) << (SH_W'(lp) + SH_W'(WORD_SHIFT)))
               + (ADDR_W'(entry_idx) << WORD_SHIFT);
  end

  // decide the work item at the queue head
  always_comb begin
    walk_offset_nxt = walk_offset_r;
    levels_left_nxt = levels_left_r;
    walk_busy_nxt   = walk_busy_r;
    tab_we          = 1'b0;
    res_valid       = 1'b0;
    res_status      = ST_REJECT;
    res_blk         = '0;
    do_issue        = 1'b0;
    issue_blk       = head.value;
    issue_lev       = head.level;
    issue_off       = head.value;
    if (pop) begin
      case (head.kind)
        K_LOAD: begin
          if (walk_busy_r) res_valid = 1'b1;
          else             tab_we    = 1'b1;
        end
        K_BEYOND: begin
          res_valid = 1'b1;
          if (!walk_busy_r) res_status = ST_BEYOND;
        end
        K_DIRECT: begin
          res_valid = 1'b1;
          if (!walk_busy_r) begin
            if (slot_ptr == '0) begin
              res_status = ST_HOLE;
            end else begin
              res_status = ST_MAPPED;
              res_blk    = slot_ptr;
            end
          end
        end
        K_INDIRECT: begin
          res_valid = 1'b1;
          if (!walk_busy_r) begin
            if (slot_ptr == '0) begin
              res_status = ST_HOLE;
            end else begin
              do_issue        = 1'b1;
              issue_blk       = slot_ptr;
              walk_offset_nxt = head.value;
            end
          end
        end
        K_RESP: begin
          res_valid = 1'b1;
          if (walk_busy_r) begin
            if (head.value == '0) begin
              walk_busy_nxt   = 1'b0;
              levels_left_nxt = '0;
              res_status      = ST_HOLE;
            end else if (levels_left_r == '0) begin
              walk_busy_nxt = 1'b0;
              res_status    = ST_MAPPED;
              res_blk       = head.value;
            end else begin
              do_issue  = 1'b1;
              issue_lev = levels_left_r - LEV_W'(1);
              issue_off = walk_offset_r;
            end
          end
        end
        default: begin
          res_valid = 1'b1;
        end
      endcase
      if (do_issue) begin
        res_status      = ST_READ;
        levels_left_nxt = issue_lev;
        walk_busy_nxt   = 1'b1;
      end
    end
  end

  // result register next value
  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    addr_nxt      = addr_r;
    blk_nxt       = blk_r;
    if (pop) begin
      out_valid_nxt = res_valid;
      status_nxt    = res_status;
      addr_nxt      = do_issue ? issue_addr : '0;
      blk_nxt       = res_blk;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_offset_r <= '0;
      levels_left_r <= '0;
      walk_busy_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      walk_offset_r <= walk_offset_nxt;
      levels_left_r <= levels_left_nxt;
      walk_busy_r   <= walk_busy_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    addr_r   <= addr_nxt;
    blk_r    <= blk_nxt;
  end

  // pointer slots, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POINTER_SLOTS; i++) begin
        ptr_tab_r[i] <= '0;
      end
    end else if (tab_we) begin
      ptr_tab_r[head.slot] <= head.value;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.read_address = addr_r;
  assign out_ch.block_number = blk_r;

endmodule

FILE: rtl/ext2_block_map_walker_core.sv
// ----------------------------------------------------------------------------
// ext2_block_map_walker_core
// Maps file block indexes to physical blocks through the ext2 pointer tree.
// ----------------------------------------------------------------------------
// Load the 15 inode pointers with load beats, then send a lookup beat. The
// block answers with mapped, hole or beyond map, or with a read request for
// one pointer word; feed each word back as a response beat until the walk
// ends. One beat is accepted per cycle while the front queue has room. An
// accepted beat is registered in the queue, and its result is then loaded
// into the output register; a stalled result holds the queue, and the input
// stalls once the queue is full. The pace of a walk is set by the memory
// round trip outside the block, one response beat per indirect level. Beats
// out of turn, an unknown command or a slot past 14 come back as rejected.
// log_block_size is written on cfg_we/cfg_wdata; the user must write it only
// while nothing is in flight, the block itself does not enforce this. Reset
// clears control state, pointer slots and block size, but not the result
// payload or queue storage; there is no clearing pass.
module ext2_block_map_walker_core #(
  parameter int QUEUE_DEPTH = e2bmw_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  e2bmw_in_if.sink                    in_ch,
  e2bmw_out_if.source                 out_ch,
  input  logic                        cfg_we,
  input  logic [e2bmw_pkg::LOG_W-1:0] cfg_wdata
);
  import e2bmw_pkg::*;

  logic [LOG_W-1:0] cfg_log_r;
  logic [LOG_W-1:0] lg_eff;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  entry_t           push_entry;
  entry_t           head_entry;

  // block size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_log_r <= '0;
    end else if (cfg_we) begin
      cfg_log_r <= cfg_wdata;
    end
  end

  assign lg_eff = eff_log(cfg_log_r);

  e2bmw_front u_front (
    .in_ch      (in_ch),
    .lg         (lg_eff),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  e2bmw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  e2bmw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .lg         (lg_eff),
    .head       (head_entry),
    .head_valid (!q_empty),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

FILE: rtl/e2bmw_checker.sv
// ----------------------------------------------------------------------------
// e2bmw_checker
// Port-level checks on the result channel of the block map walker.
// ----------------------------------------------------------------------------
module e2bmw_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [e2bmw_pkg::STATUS_W-1:0] out_status,
  input logic [e2bmw_pkg::ADDR_W-1:0]   out_read_address,
  input logic [e2bmw_pkg::WORD_W-1:0]   out_block_number
);
  import e2bmw_pkg::*;

  // a stalled result beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // address only rides with a read request
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_READ) |-> out_read_address == '0)
    else $error("read address set on a non-read result");

  // block number only rides with a mapped result
  a_blk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_MAPPED) |-> out_block_number == '0)
    else $error("block number set on a non-mapped result");

  // a mapped result never names block zero
  a_mapped_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_MAPPED) |-> out_block_number != '0)
    else $error("mapped result with block zero");

endmodule

bind ext2_block_map_walker_core e2bmw_checker u_e2bmw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_read_address (out_ch.read_address),
  .out_block_number (out_ch.block_number)
);
